// ===== rtl/websocket_frame_deframer_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the frame deframer
// Concurrent checks on the rising clock edge, disabled while reset is low.
// ---------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication
`define WFD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication
`define WFD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ===== rtl/wfd_pkg.sv =====
// ---------------------------------------------------------------------------
// wfd_pkg
// Shared types and constants of the frame deframer.
// ---------------------------------------------------------------------------
package wfd_pkg;

  localparam int DataW  = 8;
  localparam int OpW    = 4;
  localparam int CntW   = 21;
  localparam int LenW   = 64;
  localparam int IdxW   = 4;
  localparam int UserW  = 1 + OpW + 1;

  // Result queue between parser and output stage
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [CntW-1:0] MaxMsgReset = 21'd8192;

  // Header length codes and field sizes
  localparam logic [6:0]      Len16Code = 7'd126;
  localparam logic [6:0]      Len64Code = 7'd127;
  localparam logic [IdxW-1:0] Ext16Bytes = 4'd2;
  localparam logic [IdxW-1:0] Ext64Bytes = 4'd8;
  localparam logic [IdxW-1:0] KeyBytes   = 4'd4;

  // Opcodes
  localparam logic [OpW-1:0] OpCont  = 4'h0;
  localparam logic [OpW-1:0] OpText  = 4'h1;
  localparam logic [OpW-1:0] OpBin   = 4'h2;
  localparam logic [OpW-1:0] OpClose = 4'h8;
  localparam logic [OpW-1:0] OpPing  = 4'h9;
  localparam logic [OpW-1:0] OpPong  = 4'hA;

  typedef enum logic [2:0] {
    PhHdr0,
    PhHdr1,
    PhExt,
    PhKey,
    PhData,
    PhStuck
  } phase_e;

  typedef struct packed {
    logic [DataW-1:0] out_byte;
    logic             has_byte;
    logic [OpW-1:0]   frame_opcode;
    logic             end_of_message;
    logic             overflow_error;
  } result_t;

endpackage

// ===== rtl/wfd_parser.sv =====
// ---------------------------------------------------------------------------
// wfd_parser
// Front end: walks the frame header byte by byte, checks the message size
// and turns payload bytes into unmasked result items.
// ---------------------------------------------------------------------------
module wfd_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [wfd_pkg::DataW-1:0] byte_i,
  input  logic                     cfg_we_i,
  input  logic [wfd_pkg::CntW-1:0] cfg_wdata_i,
  output logic                     res_valid_o,
  output wfd_pkg::result_t         res_o
);
  import wfd_pkg::*;
  `include "websocket_frame_deframer_core_assert.svh"

  phase_e            phase_q, phase_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              fin_q, fin_d;
  logic              mask_q, mask_d;
  logic [OpW-1:0]    op_q, op_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   rem_q, rem_d;
  logic [31:0]       key_q, key_d;
  logic [1:0]        kidx_q, kidx_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   lim_q;

  logic [LenW-1:0]   hdr_len;
  logic              hdr_done;
  logic              is_ctrl;
  logic              len_hi;
  logic [CntW-1:0]   len_lo;
  logic [CntW-1:0]   room;
  logic              bad;
  logic              len_zero;
  logic              data_last;
  logic [DataW-1:0]  key_byte;

  // Map unknown opcodes to close
  function automatic logic [OpW-1:0] map_op(input logic [OpW-1:0] op);
    logic [OpW-1:0] r;
    case (op) inside
      OpCont, OpText, OpBin, OpClose, OpPing, OpPong: r = op;
      default: r = OpClose;
    endcase
    return r;
  endfunction

  // Decode header completion and size check
  always_comb begin
    case (phase_q)
      PhHdr1:  hdr_len = {{(LenW-7){1'b0}}, byte_i[6:0]};
      PhExt:   hdr_len = {len_q[LenW-DataW-1:0], byte_i};
      default: hdr_len = len_q;
    endcase
    case (phase_q)
      PhHdr1:  hdr_done = (byte_i[6:0] != Len16Code) && (byte_i[6:0] != Len64Code)
                          && !byte_i[7];
      PhExt:   hdr_done = (idx_q == 4'd1) && !mask_q;
      PhKey:   hdr_done = (idx_q == 4'd1);
      default: hdr_done = 1'b0;
    endcase
    is_ctrl  = op_q[OpW-1];
    len_hi   = |hdr_len[LenW-1:CntW];
    len_lo   = hdr_len[CntW-1:0];
    room     = lim_q - cnt_q;
    len_zero = (hdr_len == '0);
    if (is_ctrl) begin
      bad = len_hi || (len_lo > lim_q);
    end else begin
      bad = (cnt_q > lim_q) || len_hi || (len_lo > room);
    end
    data_last = (rem_q == {{(LenW-1){1'b0}}, 1'b1});
    case (kidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    fin_d   = fin_q;
    mask_d  = mask_q;
    op_d    = op_q;
    len_d   = len_q;
    rem_d   = rem_q;
    key_d   = key_q;
    kidx_d  = kidx_q;
    cnt_d   = cnt_q;
    if (accept_i) begin
      case (phase_q)
        PhHdr0: begin
          fin_d   = byte_i[7];
          op_d    = map_op(byte_i[OpW-1:0]);
          key_d   = '0;
          len_d   = '0;
          idx_d   = '0;
          phase_d = PhHdr1;
        end
        PhHdr1: begin
          mask_d = byte_i[7];
          if (byte_i[6:0] == Len16Code) begin
            idx_d   = Ext16Bytes;
            phase_d = PhExt;
          end else if (byte_i[6:0] == Len64Code) begin
            idx_d   = Ext64Bytes;
            phase_d = PhExt;
          end else begin
            len_d = hdr_len;
            if (byte_i[7]) begin
              idx_d   = KeyBytes;
              phase_d = PhKey;
            end
          end
        end
        PhExt: begin
          len_d = hdr_len;
          idx_d = idx_q - 4'd1;
          if ((idx_q == 4'd1) && mask_q) begin
            idx_d   = KeyBytes;
            phase_d = PhKey;
          end
        end
        PhKey: begin
          key_d = {key_q[23:0], byte_i};
          idx_d = idx_q - 4'd1;
        end
        PhData: begin
          kidx_d = kidx_q + 2'd1;
          rem_d  = rem_q - {{(LenW-1){1'b0}}, 1'b1};
          if (data_last) begin
            phase_d = PhHdr0;
            if (is_ctrl || fin_q) begin
              cnt_d = '0;
            end
          end
        end
        PhStuck: begin
          phase_d = PhStuck;
        end
        default: begin
          phase_d = PhHdr0;
        end
      endcase
      // Header complete: check size, then stop on overflow, start payload or close the frame
      if (hdr_done) begin
        if (bad) begin
          phase_d = PhStuck;
        end else begin
          if (!is_ctrl) begin
            cnt_d = cnt_q + len_lo;
          end
          kidx_d = '0;
          if (len_zero) begin
            phase_d = PhHdr0;
            if (is_ctrl || fin_q) begin
              cnt_d = '0;
            end
          end else begin
            rem_d   = hdr_len;
            phase_d = PhData;
          end
        end
      end
    end
  end

  // Result item for the byte at the input
  always_comb begin
    res_valid_o          = 1'b0;
    res_o.out_byte       = '0;
    res_o.has_byte       = 1'b0;
    res_o.frame_opcode   = op_q;
    res_o.end_of_message = 1'b0;
    res_o.overflow_error = 1'b0;
    if (hdr_done) begin
      if (bad) begin
        res_valid_o          = 1'b1;
        res_o.overflow_error = 1'b1;
      end else if (len_zero && (is_ctrl || fin_q)) begin
        res_valid_o          = 1'b1;
        res_o.end_of_message = 1'b1;
      end
    end else if (phase_q == PhData) begin
      res_valid_o          = 1'b1;
      res_o.has_byte       = 1'b1;
      res_o.out_byte       = byte_i ^ key_byte;
      res_o.end_of_message = data_last && (is_ctrl || fin_q);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHdr0;
      idx_q   <= '0;
      fin_q   <= 1'b0;
      mask_q  <= 1'b0;
      op_q    <= '0;
      len_q   <= '0;
      rem_q   <= '0;
      key_q   <= '0;
      kidx_q  <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      fin_q   <= fin_d;
      mask_q  <= mask_d;
      op_q    <= op_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      key_q   <= key_d;
      kidx_q  <= kidx_d;
      cnt_q   <= cnt_d;
    end
  end

  // Message size limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= MaxMsgReset;
    end else if (cfg_we_i) begin
      lim_q <= cfg_wdata_i;
    end
  end

  `WFD_ASSERT_IMP(a_stuck_silent, clk_i, rst_ni, phase_q == PhStuck, !res_valid_o)
  `WFD_ASSERT_NXT(a_err_sticks, clk_i, rst_ni,
                  accept_i && res_valid_o && res_o.overflow_error, phase_q == PhStuck)
  `WFD_ASSERT_NXT(a_last_byte_ends, clk_i, rst_ni,
                  accept_i && (phase_q == PhData) && data_last, phase_q == PhHdr0)

endmodule

// ===== rtl/wfd_queue.sv =====
// ---------------------------------------------------------------------------
// wfd_queue
// Short result queue that decouples the parser from the output stage.
// ---------------------------------------------------------------------------
module wfd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wfd_pkg::result_t push_data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output wfd_pkg::result_t head_o
);
  import wfd_pkg::*;
  `include "websocket_frame_deframer_core_assert.svh"

  result_t          mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  // Status and head
  always_comb begin
    ready_o = (cnt_q != QCntW'(QueueDepth));
    valid_o = (cnt_q != '0);
    head_o  = mem_q[rd_q];
  end

  // Advance pointers and count
  always_comb begin
    wr_d  = push_i ? wr_q + QPtrW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + QPtrW'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `WFD_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, cnt_q == QCntW'(QueueDepth), !push_i)
  `WFD_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, cnt_q == '0, !pop_i)
  `WFD_ASSERT_NXT(a_count_up, clk_i, rst_ni, push_i && !pop_i,
                  cnt_q == $past(cnt_q) + QCntW'(1))

endmodule

// ===== rtl/wfd_emit.sv =====
// ---------------------------------------------------------------------------
// wfd_emit
// Back end: output register that presents queued result items on the
// master stream and pulls the next one as soon as the slot frees.
// ---------------------------------------------------------------------------
module wfd_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  wfd_pkg::result_t q_head_i,
  output logic             q_pop_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output wfd_pkg::result_t out_o
);
  import wfd_pkg::*;

  logic    valid_q, valid_d;
  result_t out_q;

  // Load when the slot is empty or being taken
  always_comb begin
    q_pop_o = q_valid_i && (!valid_q || out_ready_i);
    valid_d = valid_q;
    if (q_pop_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= q_head_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/websocket_frame_deframer_core.sv =====
// ---------------------------------------------------------------------------
// websocket_frame_deframer_core
// Streaming frame parser with payload unmasking and message size limit.
// ---------------------------------------------------------------------------
// Takes one received byte per clock on the slave stream while the queue has
// room, and gives at most one result item per byte on the master stream.
// A four-entry result queue and an output register sit between the header
// parser and the master side, so input keeps flowing while the sink stalls;
// s_axis_tready_o falls only once the queue is full.
// Payload bytes carry their frame opcode and tlast marks the end of a
// message; a message too long for cfg_wdata_i's limit gives one error item
// and the block then accepts bytes silently until reset. The limit may be
// written at any time the block is idle. No clearing pass after reset.
module websocket_frame_deframer_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Limit register: max_message_bytes
  input  logic                      cfg_we_i,
  input  logic [wfd_pkg::CntW-1:0]  cfg_wdata_i,
  // Slave stream
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [wfd_pkg::DataW-1:0] s_axis_tdata_i,  // [7:0] in_byte
  // Master stream
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [wfd_pkg::DataW-1:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic [wfd_pkg::UserW-1:0] m_axis_tuser_o,  // [0] has_byte, [4:1] frame_opcode,
                                                     // [5] overflow_error
  output logic                      m_axis_tlast_o   // end_of_message
);
  import wfd_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  logic    q_ready;
  logic    q_valid;
  logic    q_pop;
  result_t q_head;
  result_t out;

  assign s_axis_tready_o = q_ready;
  assign accept          = s_axis_tvalid_i && q_ready;

  wfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && res_valid),
    .push_data_i (res),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  wfd_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_o       (out)
  );

  // Pack the result onto the master stream
  assign m_axis_tdata_o = out.out_byte;
  assign m_axis_tuser_o = {out.overflow_error, out.frame_opcode, out.has_byte};
  assign m_axis_tlast_o = out.end_of_message;

endmodule
